// ----- rtl/fqd_pkg.sv -----
// fqd_pkg: shared widths, codes and state type of the fifo queue with dump
// no dependencies; imported by fqd_ram users and the top level

package fqd_pkg;

   // payload widths
   localparam int VALUE_W    = 17;
   localparam int CMD_W      = 2;
   localparam int KIND_W     = 2;
   localparam int REQ_DATA_W = 24;   // cmd and value, padded to whole bytes
   localparam int RSP_DATA_W = 24;   // data, padded to whole bytes
   localparam int RSP_USER_W = 2;    // kind

   // default queue depth
   localparam int DEPTH_DEF  = 64;

   // command codes carried by an input item
   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ  = 2'd0,
      CMD_DEQ  = 2'd1,
      CMD_SHOW = 2'd2
   } cmd_type;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_REMOVED  = 2'd0,
      KIND_LISTED   = 2'd1,
      KIND_OVERFLOW = 2'd2
   } kind_type;

   // control states
   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

endpackage

// ----- rtl/fqd_ram.sv -----
// fqd_ram: generic single-write, single-read ram with registered read data
// no dependencies; read data holds while rd_en is low

module fqd_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fifo_queue_with_dump.sv -----
// fifo_queue_with_dump: fifo queue in a ring ram with dequeue and full listing
// depends on fqd_pkg and fqd_ram
//
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tdata[1:0] cmd, tdata[18:2] value
//  rsp     | out | rsp_tvalid/tready   | tdata[16:0] data, tuser kind, tlast last
//
// enqueue: one item per cycle while idle and the rsp side does not stall, written straight into the ring ram
// dequeue: one ram read, then the result loads the output register
// show of n stored values: one entry per cycle off the single read port while the rsp side does not stall
// reset clears state, head, tail, count, walk count and output valid; ram contents stay undefined until written
// a stalled rsp side freezes the walk; the read data register holds the pending value

module fifo_queue_with_dump #(
   parameter int DEPTH = fqd_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [fqd_pkg::REQ_DATA_W-1:0] req_tdata,   // cmd [1:0], value [18:2], zeros
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fqd_pkg::RSP_DATA_W-1:0] rsp_tdata,   // data [16:0], zeros
   output logic [fqd_pkg::RSP_USER_W-1:0] rsp_tuser,   // kind [1:0]
   output logic                          rsp_tlast     // last
);

   import fqd_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   // control registers
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] walk_idx_ff, walk_idx_in;
   logic [CNT_W-1:0] walk_left_ff, walk_left_in;
   kind_type         walk_kind_ff, walk_kind_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   kind_type           out_kind_ff, out_kind_in;
   logic [VALUE_W-1:0] out_data_ff, out_data_in;
   logic               out_last_ff, out_last_in;

   // ram ports
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   // decoded input
   cmd_type            req_cmd;
   logic [VALUE_W-1:0] req_value;
   logic               req_accept;
   logic               out_free;
   logic               is_empty;
   logic               is_full;

   assign req_cmd    = cmd_type'(req_tdata[CMD_W-1:0]);
   assign req_value  = req_tdata[CMD_W +: VALUE_W];
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign is_empty   = (fill_ff == '0);
   assign is_full    = (fill_ff == CNT_FULL);

   // ring index step with wrap
   function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      nxt = (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
      return nxt;
   endfunction

   // ring store; a read and a write never fall in the same cycle, so no same-entry overlap
   fqd_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && !is_empty &&
                (req_cmd == CMD_DEQ || req_cmd == CMD_SHOW)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free && walk_left_ff == CNT_ONE) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      req_tready   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      walk_idx_in  = walk_idx_ff;
      walk_left_in = walk_left_ff;
      walk_kind_in = walk_kind_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = out_free;
            if (req_accept) begin
               case (req_cmd)
                  CMD_ENQ: begin
                     if (is_full) begin
                        out_valid_in = 1'b1;
                        out_kind_in  = KIND_OVERFLOW;
                        out_data_in  = '0;
                        out_last_in  = 1'b1;
                     end else begin
                        ram_wr_en = 1'b1;
                        tail_in   = step_idx(tail_ff);
                        fill_in   = fill_ff + CNT_ONE;
                     end
                  end
                  CMD_DEQ: begin
                     if (!is_empty) begin
                        ram_rd_en    = 1'b1;
                        head_in      = step_idx(head_ff);
                        fill_in      = fill_ff - CNT_ONE;
                        walk_left_in = CNT_ONE;
                        walk_kind_in = KIND_REMOVED;
                     end
                  end
                  CMD_SHOW: begin
                     if (!is_empty) begin
                        ram_rd_en    = 1'b1;
                        walk_idx_in  = step_idx(head_ff);
                        walk_left_in = fill_ff;
                        walk_kind_in = KIND_LISTED;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DRAIN: begin
            // hand the read value over and fetch the next entry in the same cycle
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = walk_kind_ff;
               out_data_in  = ram_rd_data;
               out_last_in  = (walk_left_ff == CNT_ONE);
               walk_left_in = walk_left_ff - CNT_ONE;
               if (walk_left_ff != CNT_ONE) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = walk_idx_ff;
                  walk_idx_in = step_idx(walk_idx_ff);
               end
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         walk_left_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         walk_left_ff <= walk_left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      walk_idx_ff  <= walk_idx_in;
      walk_kind_ff <= walk_kind_in;
      out_kind_ff  <= out_kind_in;
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
   end

   // result port
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_data_ff);
   assign rsp_tuser  = RSP_USER_W'(out_kind_ff);
   assign rsp_tlast  = out_last_ff;

   // count never passes the ring depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_FULL)
      else $error("fill count above depth");

   // a walk in progress always has an entry left
   a_walk_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> walk_left_ff != '0)
      else $error("drain state with nothing left");

   // a stored enqueue grows the count by one
   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_cmd == CMD_ENQ && !is_full |=>
         fill_ff == $past(fill_ff) + CNT_ONE)
      else $error("enqueue did not advance fill count");

   // overflow results carry zero data and close the item
   a_overflow_form: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == KIND_OVERFLOW |-> out_data_ff == '0 && out_last_ff)
      else $error("malformed overflow result");

   // no new item is taken while a walk is running
   a_no_accept_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> !req_accept)
      else $error("item accepted during drain");

endmodule
